// ===== src/set_assoc_cache_tag_controller_assert.svh =====
// assertion macros for the cache tag controller
// used by the controller and top level files
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SACTC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SACTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/sactc_pkg.sv =====
// shared types and constants of the cache tag controller
// no dependencies
`timescale 1ns / 1ps
package sactc_pkg;
   localparam int MaxSets = 256;
   localparam int MaxWays = 8;
   localparam int SetBits = 8;
   localparam int WayBits = 3;
   localparam int Lines = MaxSets * MaxWays;
   localparam int LineBits = 11;
   localparam int TagBits = 30;
   localparam int StampBits = 32;
   localparam int CostBits = 18;
   // way entry: valid, dirty, tag, load stamp, access stamp
   localparam int EntryBits = 2 + TagBits + 2 * StampBits;
   localparam logic [17:0] MissUnit = 18'd100;

   localparam logic [2:0] CsrSets = 3'd0;
   localparam logic [2:0] CsrWays = 3'd1;
   localparam logic [2:0] CsrBlock = 3'd2;
   localparam logic [2:0] CsrWalloc = 3'd3;
   localparam logic [2:0] CsrWthru = 3'd4;
   localparam logic [2:0] CsrLru = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN, ST_WRITE, ST_RESP
   } state_type;

   typedef struct packed {
      logic valid;
      logic dirty;
      logic [TagBits-1:0] tag;
      logic [StampBits-1:0] load_stamp;
      logic [StampBits-1:0] access_stamp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic clear_write;
      logic [LineBits-1:0] clear_addr;
      logic capture;
      logic read;
      logic [WayBits-1:0] way;
      logic scan;
      logic write;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
   } status_type;
endpackage

// ===== src/sactc_ram.sv =====
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module sactc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0] wdata,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;
   // write one word when enabled and read the word at the address
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

// ===== src/sactc_ctrl.sv =====
// controller state machine of the cache tag controller
// depends on sactc_pkg and the assertion header
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_controller_assert.svh"
module sactc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  logic [3:0] ways_eff,
   input  sactc_pkg::status_type status,
   output sactc_pkg::cmd_type cmd
);
   sactc_pkg::state_type state_ff, state_in;
   logic [sactc_pkg::LineBits:0] clr_ff, clr_in;
   logic [3:0] way_ff, way_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sactc_pkg::ST_CLEAR;
         clr_ff <= '0;
         way_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         way_ff <= way_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      way_in = way_ff;
      cmd = '0;
      cmd.clear_addr = clr_ff[sactc_pkg::LineBits-1:0];
      cmd.way = way_ff[sactc_pkg::WayBits-1:0];
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sactc_pkg::ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff[sactc_pkg::LineBits-1:0] == '1) begin
               state_in = sactc_pkg::ST_IDLE;
            end
         end
         sactc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
            way_in = '0;
            if (req_valid) begin
               state_in = sactc_pkg::ST_READ;
            end
         end
         sactc_pkg::ST_READ: begin
            // issue read of current way
            cmd.read = 1'b1;
            state_in = sactc_pkg::ST_SCAN;
         end
         sactc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            way_in = way_ff + 1'b1;
            if (way_ff + 1'b1 >= ways_eff) begin
               state_in = sactc_pkg::ST_WRITE;
            end else begin
               state_in = sactc_pkg::ST_READ;
            end
         end
         sactc_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = sactc_pkg::ST_RESP;
         end
         sactc_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.finish = 1'b1;
               state_in = sactc_pkg::ST_IDLE;
            end
         end
         default: state_in = sactc_pkg::ST_IDLE;
      endcase
   end

   `SACTC_ASSERT_IMP(a_ready_idle, req_ready, state_ff == sactc_pkg::ST_IDLE)
   `SACTC_ASSERT_IMP(a_no_overlap, req_ready, !rsp_valid)
   `SACTC_ASSERT_NEXT(a_write_resp, cmd.write, rsp_valid)
   `SACTC_ASSERT_IMP(a_way_range, cmd.scan, way_ff < ways_eff)
   `SACTC_ASSERT_IMP(a_status_done, status.done, state_ff == sactc_pkg::ST_RESP)
endmodule

// ===== src/sactc_dp.sv =====
// datapath: way ram, tag compare, victim choice and cost
// depends on sactc_pkg and sactc_ram
`timescale 1ns / 1ps
module sactc_dp (
   input  logic clock,
   input  logic reset,
   input  logic req_opcode,
   input  logic [31:0] req_address,
   input  logic [3:0] sets_log2,
   input  logic [3:0] block_log2,
   input  logic walloc,
   input  logic wthru,
   input  logic lru_policy,
   input  sactc_pkg::cmd_type cmd,
   output sactc_pkg::status_type status,
   output logic rsp_hit,
   output logic rsp_dirty_evicted,
   output logic [17:0] rsp_cycle_cost
);
   logic store_ff;
   logic [sactc_pkg::TagBits-1:0] tag_ff;
   logic [sactc_pkg::SetBits-1:0] set_ff;
   logic hit_ff, hit_in;
   logic [sactc_pkg::WayBits-1:0] hway_ff, hway_in;
   logic inv_ff, inv_in;
   logic [sactc_pkg::WayBits-1:0] vway_ff, vway_in;
   logic [sactc_pkg::StampBits-1:0] best_ff, best_in;
   logic vdirty_ff, vdirty_in;
   sactc_pkg::entry_type hent_ff, hent_in;
   logic [sactc_pkg::StampBits-1:0] counter_ff;
   logic [17:0] fill;
   logic res_hit_ff, res_dev_ff;
   logic [17:0] res_cost_ff;

   logic ram_we;
   logic [sactc_pkg::LineBits-1:0] ram_addr;
   sactc_pkg::entry_type ram_wdata, ram_rdata, wr_entry;
   logic [sactc_pkg::WayBits-1:0] wr_way;
   logic [sactc_pkg::StampBits-1:0] stamp, cand;
   logic miss_alloc, dev;
   logic [17:0] cost;
   logic [31:0] sh_blk, sh_tag;

   sactc_ram #(.Width(sactc_pkg::EntryBits), .Depth(sactc_pkg::Lines)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   // block transfer cost
   assign fill = sactc_pkg::MissUnit << (block_log2 - 4'd2);
   assign stamp = counter_ff + 1'b1;

   // address split into set and tag
   assign sh_blk = req_address >> block_log2;
   assign sh_tag = sh_blk >> sets_log2;

   // result of the scan
   always_comb begin
      miss_alloc = !hit_ff && !(store_ff && !walloc);
      wr_way = hit_ff ? hway_ff : vway_ff;
      dev = miss_alloc && vdirty_ff && !wthru;
      wr_entry = hent_ff;
      wr_entry.access_stamp = stamp;
      if (hit_ff) begin
         if (store_ff && !wthru) wr_entry.dirty = 1'b1;
      end else begin
         wr_entry.valid = 1'b1;
         wr_entry.tag = tag_ff;
         wr_entry.load_stamp = stamp;
         wr_entry.dirty = store_ff && !wthru;
      end
      if (hit_ff) begin
         cost = (store_ff && wthru) ? sactc_pkg::MissUnit : 18'd1;
      end else if (!miss_alloc) begin
         cost = sactc_pkg::MissUnit;
      end else if (!store_ff) begin
         cost = dev ? fill << 1 : fill;
      end else if (wthru) begin
         cost = sactc_pkg::MissUnit + fill;
      end else begin
         cost = dev ? fill << 1 : fill;
      end
   end

   // ram port mux
   always_comb begin
      ram_we = cmd.clear_write || (cmd.write && (hit_ff || miss_alloc));
      ram_addr = {set_ff, cmd.way};
      ram_wdata = '0;
      if (cmd.clear_write) begin
         ram_addr = cmd.clear_addr;
      end else if (cmd.write) begin
         ram_addr = {set_ff, wr_way};
         ram_wdata = wr_entry;
      end
   end

   // scan one way per read
   always_comb begin
      hit_in = hit_ff;
      hway_in = hway_ff;
      inv_in = inv_ff;
      vway_in = vway_ff;
      best_in = best_ff;
      vdirty_in = vdirty_ff;
      hent_in = hent_ff;
      cand = lru_policy ? ram_rdata.access_stamp : ram_rdata.load_stamp;
      if (cmd.capture) begin
         hit_in = 1'b0;
         inv_in = 1'b0;
         vway_in = '0;
         best_in = '1;
         vdirty_in = 1'b0;
      end else if (cmd.scan) begin
         if (!hit_ff && ram_rdata.valid && ram_rdata.tag == tag_ff) begin
            hit_in = 1'b1;
            hway_in = cmd.way;
            hent_in = ram_rdata;
         end
         if (!inv_ff) begin
            if (!ram_rdata.valid) begin
               inv_in = 1'b1;
               vway_in = cmd.way;
               vdirty_in = ram_rdata.dirty;
            end else if (cmd.way == '0 || cand < best_ff) begin
               best_in = cand;
               vway_in = cmd.way;
               vdirty_in = ram_rdata.dirty;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      hway_ff <= hway_in;
      inv_ff <= inv_in;
      vway_ff <= vway_in;
      best_ff <= best_in;
      vdirty_ff <= vdirty_in;
      hent_ff <= hent_in;
      if (cmd.capture) begin
         store_ff <= req_opcode;
         set_ff <= sh_blk[sactc_pkg::SetBits-1:0] &
            sactc_pkg::SetBits'((9'd1 << sets_log2) - 9'd1);
         tag_ff <= sh_tag[sactc_pkg::TagBits-1:0];
      end
      if (cmd.write) begin
         res_hit_ff <= hit_ff;
         res_dev_ff <= dev;
         res_cost_ff <= cost;
      end
   end

   // access counter
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (cmd.write && (hit_ff || miss_alloc)) begin
         counter_ff <= stamp;
      end
   end

   assign status.done = cmd.finish;
   assign rsp_hit = res_hit_ff;
   assign rsp_dirty_evicted = res_dev_ff;
   assign rsp_cycle_cost = res_cost_ff;
endmodule

// ===== src/set_assoc_cache_tag_controller.sv =====
// Set-associative cache tag store. After reset a clearing pass writes all 2048
// entries of the way memory; no request is taken then. Each access then reads
// every way of the set in turn through the single port of the way memory, then
// does at most one write back before the response beat.
// depends on sactc_pkg, sactc_ctrl, sactc_dp and the assertion header
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_controller_assert.svh"
module set_assoc_cache_tag_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_opcode,
   input  logic [31:0] req_address,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit,
   output logic rsp_dirty_evicted,
   output logic [17:0] rsp_cycle_cost,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   logic [3:0] sets_ff, ways_ff, block_ff;
   logic walloc_ff, wthru_ff, lru_ff;
   logic [3:0] sets_eff, ways_eff, block_eff;
   sactc_pkg::cmd_type cmd;
   sactc_pkg::status_type status;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sets_ff <= 4'd0;
         ways_ff <= 4'd1;
         block_ff <= 4'd4;
         walloc_ff <= 1'b1;
         wthru_ff <= 1'b0;
         lru_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            sactc_pkg::CsrSets: sets_ff <= csr_data[3:0];
            sactc_pkg::CsrWays: ways_ff <= csr_data[3:0];
            sactc_pkg::CsrBlock: block_ff <= csr_data[3:0];
            sactc_pkg::CsrWalloc: walloc_ff <= csr_data[0];
            sactc_pkg::CsrWthru: wthru_ff <= csr_data[0];
            sactc_pkg::CsrLru: lru_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp geometry
   assign sets_eff = (sets_ff > 4'd8) ? 4'd8 : sets_ff;
   assign ways_eff = (ways_ff == 4'd0) ? 4'd1 : ((ways_ff > 4'd8) ? 4'd8 : ways_ff);
   assign block_eff = (block_ff < 4'd2) ? 4'd2 : ((block_ff > 4'd12) ? 4'd12 : block_ff);

   sactc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .ways_eff(ways_eff),
      .status(status), .cmd(cmd)
   );

   sactc_dp u_dp (
      .clock(clock), .reset(reset), .req_opcode(req_opcode), .req_address(req_address),
      .sets_log2(sets_eff), .block_log2(block_eff), .walloc(walloc_ff),
      .wthru(wthru_ff), .lru_policy(lru_ff), .cmd(cmd), .status(status),
      .rsp_hit(rsp_hit), .rsp_dirty_evicted(rsp_dirty_evicted),
      .rsp_cycle_cost(rsp_cycle_cost)
   );

   `SACTC_ASSERT_IMP(a_dev_miss, rsp_valid && rsp_dirty_evicted, !rsp_hit)
   `SACTC_ASSERT_IMP(a_hit_cost, rsp_valid && rsp_hit,
      rsp_cycle_cost == 18'd1 || rsp_cycle_cost == sactc_pkg::MissUnit)
   `SACTC_ASSERT_IMP(a_cost_nonzero, rsp_valid, rsp_cycle_cost != 18'd0)
endmodule
